/* src/rrag_pkg.sv */
// Package for the raster rotation address generator.
// Holds the fixed field widths, the register index codes and the rotation type.
// No dependencies.
package rrag_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_OUT_W  = 24;
    localparam int T8_W       = 8;
    localparam int T16_W      = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SRC_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_SRC_HEIGHT = 2'd1;
    localparam cfg_idx_t REG_ROTATION   = 2'd2;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

endpackage

/* src/raster_rotation_address_generator.sv */
// Raster rotation address generator: destination index of each source pixel for 0/90/180/270.
// Depends on rrag_pkg and rrag_pos_tracker.
// Input goes to the operand register, then the multiply-add result to the result register.
// Throughput: one pixel per cycle unless m_ready stalls; a waiting result leaves room for one.
// Reset (aresetn, synchronous, active low): width 1, height 1, no rotation, position at origin.
module raster_rotation_address_generator #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  rrag_pkg::cfg_idx_t                  cfg_index,
    input  logic [rrag_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rrag_pkg::T8_W-1:0]           s_thresh8,
    input  logic [rrag_pkg::T16_W-1:0]          s_thresh16,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rrag_pkg::IDX_OUT_W-1:0]      m_dest_index,
    output logic [rrag_pkg::T8_W-1:0]           m_out8,
    output logic [rrag_pkg::T16_W-1:0]          m_out16,
    output logic                                m_last_pixel
);
    import rrag_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int SUM_W = CNT_W + DIM_W + 1;

    logic [DIM_W-1:0] w_eff_reg;
    logic [DIM_W-1:0] h_eff_reg;
    rot_t             rot_reg;
    logic [DIM_W-1:0] wdata_eff;
    logic             cfg_hit;

    logic [CNT_W-1:0] op_a, op_add;
    logic [DIM_W-1:0] op_b;
    logic             op_last;

    logic             s_fire;
    logic             a_adv;
    logic             a_valid_reg;
    logic [CNT_W-1:0] a_mul_a_reg, a_add_reg;
    logic [DIM_W-1:0] a_mul_b_reg;
    logic             a_last_reg;
    logic [T8_W-1:0]  a_t8_reg;
    logic [T16_W-1:0] a_t16_reg;
    logic [SUM_W-1:0] idx_sum;

    // A zero dimension counts as one, anything above MAX_DIM as MAX_DIM.
    always_comb begin
        if (cfg_wdata == '0) begin
            wdata_eff = DIM_W'(1);
        end else if (32'(cfg_wdata) > MAX_DIM) begin
            wdata_eff = DIM_W'(MAX_DIM);
        end else begin
            wdata_eff = DIM_W'(cfg_wdata);
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_ROTATION: cfg_hit = cfg_wr_en;
            default:                                     cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg <= DIM_W'(1);
            h_eff_reg <= DIM_W'(1);
            rot_reg   <= ROT_0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SRC_WIDTH:  w_eff_reg <= wdata_eff;
                REG_SRC_HEIGHT: h_eff_reg <= wdata_eff;
                REG_ROTATION:   rot_reg   <= rot_t'(cfg_wdata[1:0]);
                default: begin
                end
            endcase
        end
    end

    rrag_pos_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_hit),
        .advance  (s_fire),
        .w_eff    (w_eff_reg),
        .h_eff    (h_eff_reg),
        .rot      (rot_reg),
        .mul_a    (op_a),
        .mul_b    (op_b),
        .add_term (op_add),
        .last     (op_last)
    );

    // The operand stage moves on whenever the result register is empty or being drained.
    assign a_adv   = !m_valid || m_ready;
    assign s_ready = !a_valid_reg || a_adv;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid     <= 1'b0;
        end else begin
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_mul_a_reg <= op_a;
            a_mul_b_reg <= op_b;
            a_add_reg   <= op_add;
            a_last_reg  <= op_last;
            a_t8_reg    <= s_thresh8;
            a_t16_reg   <= s_thresh16;
        end
    end

    assign idx_sum = SUM_W'(a_mul_a_reg * a_mul_b_reg) + SUM_W'(a_add_reg);

    always_ff @(posedge aclk) begin
        if (a_adv && a_valid_reg) begin
            m_dest_index <= IDX_OUT_W'(idx_sum);
            m_out8       <= a_t8_reg;
            m_out16      <= a_t16_reg;
            m_last_pixel <= a_last_reg;
        end
    end

    // Effective dimensions never leave the range 1..MAX_DIM.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (w_eff_reg != '0) && (32'(w_eff_reg) <= MAX_DIM)
        && (h_eff_reg != '0) && (32'(h_eff_reg) <= MAX_DIM))
        else $error("effective dimension out of range");

    // A stalled operand stage keeps its pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_adv |=> a_valid_reg && $stable(a_mul_a_reg)
        && $stable(a_add_reg) && $stable(a_t16_reg))
        else $error("operand stage lost a pixel under stall");

    // With both stages full and the output stalled, no input transfer may happen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && m_valid && !m_ready |-> !s_fire)
        else $error("input transfer while pipeline full");

endmodule

/* src/rrag_pos_tracker.sv */
// Source raster position counters and multiply-add operand selection.
// Depends on rrag_pkg for the rotation type.
// Operands are formed so that dest_index = mul_a * mul_b + add_term.
module rrag_pos_tracker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            clear,
    input  logic                            advance,
    input  logic [$clog2(MAX_DIM+1)-1:0]    w_eff,
    input  logic [$clog2(MAX_DIM+1)-1:0]    h_eff,
    input  rrag_pkg::rot_t                  rot,
    output logic [$clog2(MAX_DIM)-1:0]      mul_a,
    output logic [$clog2(MAX_DIM+1)-1:0]    mul_b,
    output logic [$clog2(MAX_DIM)-1:0]      add_term,
    output logic                            last
);
    import rrag_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             end_col, end_row;
    logic [CNT_W-1:0] row_mirror, col_mirror;

    assign end_col = (DIM_W'(col_reg) == w_eff - DIM_W'(1));
    assign end_row = (DIM_W'(row_reg) == h_eff - DIM_W'(1));
    assign last    = end_col && end_row;

    // Mirrored positions always fit the counter width since they stay below the dimension.
    assign row_mirror = CNT_W'(h_eff - DIM_W'(1) - DIM_W'(row_reg));
    assign col_mirror = CNT_W'(w_eff - DIM_W'(1) - DIM_W'(col_reg));

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (clear) begin
            row_next = '0;
            col_next = '0;
        end else if (advance) begin
            if (end_col) begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_comb begin
        case (rot)
            ROT_90: begin
                mul_a    = col_reg;
                mul_b    = h_eff;
                add_term = row_mirror;
            end
            ROT_180: begin
                mul_a    = row_mirror;
                mul_b    = w_eff;
                add_term = col_mirror;
            end
            ROT_270: begin
                mul_a    = col_mirror;
                mul_b    = h_eff;
                add_term = row_reg;
            end
            default: begin
                mul_a    = row_reg;
                mul_b    = w_eff;
                add_term = col_reg;
            end
        endcase
    end

endmodule

/* test/tb_raster_rotation_address_generator.sv */
// Testbench for raster_rotation_address_generator: directed and random pixel streams whose
// destination indexes are predicted locally and compared field by field with each result.
// Depends on rrag_pkg and the RTL of the block; reads no files.
module tb_raster_rotation_address_generator;
    import rrag_pkg::*;

    localparam int       MAX_DIM       = 4096;
    localparam int       CYCLE_LIMIT   = 1000000;
    localparam int       RANDOM_PIXELS = 1050;
    localparam cfg_idx_t REG_UNUSED    = 2'd3;

    typedef struct packed {
        logic [T8_W-1:0]  thresh8;
        logic [T16_W-1:0] thresh16;
    } pixel_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] dest_index;
        logic [T8_W-1:0]      out8;
        logic [T16_W-1:0]     out16;
        logic                 last_pixel;
    } placed_pixel_t;

    logic                  aclk;
    logic                  aresetn    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    cfg_idx_t              cfg_index  = REG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [T8_W-1:0]       s_thresh8  = '0;
    logic [T16_W-1:0]      s_thresh16 = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [IDX_OUT_W-1:0]  m_dest_index;
    logic [T8_W-1:0]       m_out8;
    logic [T16_W-1:0]      m_out16;
    logic                  m_last_pixel;

    // Pixels waiting to be sent and destination entries waiting to come back.
    pixel_t        pixel_q[$];
    placed_pixel_t placed_q[$];

    // Local copy of the block's registers and raster position.
    logic [CFG_DATA_W-1:0] width_reg  = 13'd1;
    logic [CFG_DATA_W-1:0] height_reg = 13'd1;
    rot_t                  rot_reg    = ROT_0;
    logic [11:0]           src_row    = '0;
    logic [11:0]           src_col    = '0;

    bit          quiet     = 1'b0;
    int unsigned err_count = 0;
    int unsigned cycle_n   = 0;

    raster_rotation_address_generator #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_thresh8    (s_thresh8),
        .s_thresh16   (s_thresh16),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest_index (m_dest_index),
        .m_out8       (m_out8),
        .m_out16      (m_out16),
        .m_last_pixel (m_last_pixel)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned used_dim(logic [CFG_DATA_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return 32'(v);
    endfunction

    // Places one source pixel in the rotated array and steps the raster position.
    function automatic placed_pixel_t place_pixel(logic [T8_W-1:0] t8, logic [T16_W-1:0] t16);
        int unsigned   w, h, r, c, idx;
        logic          end_col, end_row;
        placed_pixel_t res;
        w = used_dim(width_reg);
        h = used_dim(height_reg);
        r = 32'(src_row);
        c = 32'(src_col);
        if (r >= h) r = h - 1;
        if (c >= w) c = w - 1;
        case (rot_reg)
            ROT_90:  idx = c * h + (h - 1 - r);
            ROT_180: idx = (h - 1 - r) * w + (w - 1 - c);
            ROT_270: idx = (w - 1 - c) * h + r;
            default: idx = r * w + c;
        endcase
        end_col = (c == w - 1);
        end_row = (r == h - 1);
        res.dest_index = idx[IDX_OUT_W-1:0];
        res.out8       = t8;
        res.out16      = t16;
        res.last_pixel = end_col && end_row;
        if (end_col) begin
            src_col = '0;
            src_row = end_row ? 12'd0 : 12'(r + 1);
        end else begin
            src_col = 12'(c + 1);
            src_row = 12'(r);
        end
        return res;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pause_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 75) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 9);
        return $urandom_range(20, 60);
    endfunction

    int unsigned tx_gap = 0;
    pixel_t      tx_px;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                placed_q.push_back(place_pixel(s_thresh8, s_thresh16));
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    tx_px = pixel_q.pop_front();
                    s_valid    <= 1'b1;
                    s_thresh8  <= tx_px.thresh8;
                    s_thresh16 <= tx_px.thresh16;
                    if (!quiet && $urandom_range(0, 99) < 40) tx_gap = pause_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    int unsigned   rx_stall = 0;
    placed_pixel_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (placed_q.size() == 0) begin
                    $error("result with no pixel pending: dest_index %0d", m_dest_index);
                    err_count++;
                end else begin
                    want = placed_q.pop_front();
                    if (m_dest_index !== want.dest_index) begin
                        $error("dest_index: expected %0d, got %0d", want.dest_index, m_dest_index);
                        err_count++;
                    end
                    if (m_out8 !== want.out8) begin
                        $error("out8: expected %0d, got %0d", want.out8, m_out8);
                        err_count++;
                    end
                    if (m_out16 !== want.out16) begin
                        $error("out16: expected %0d, got %0d", want.out16, m_out16);
                        err_count++;
                    end
                    if (m_last_pixel !== want.last_pixel) begin
                        $error("last_pixel: expected %0d, got %0d", want.last_pixel,
                               m_last_pixel);
                        err_count++;
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 12) begin
                rx_stall = pause_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sampled on the falling edge so that all rising-edge updates have settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || placed_q.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    // The write lands on the next rising edge; the block is idle, so the model may move now.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SRC_WIDTH:  width_reg = data;
            REG_SRC_HEIGHT: height_reg = data;
            REG_ROTATION:   rot_reg = rot_t'(data[1:0]);
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            src_row = '0;
            src_col = '0;
        end
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                             logic [CFG_DATA_W-1:0] rot);
        wait_drained();
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_ROTATION, rot);
        close_writes();
    endtask

    task automatic queue_pixel(logic [T8_W-1:0] t8, logic [T16_W-1:0] t16);
        pixel_t px;
        px.thresh8  = t8;
        px.thresh16 = t16;
        pixel_q.push_back(px);
    endtask

    task automatic queue_random(int unsigned n);
        repeat (n) queue_pixel(T8_W'($urandom), T16_W'($urandom));
    endtask

    // Small frames most of the time, so that whole frames and the wrap get exercised.
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 80) return CFG_DATA_W'($urandom_range(1, 8));
        if (p < 92) return CFG_DATA_W'($urandom_range(9, 64));
        if (p < 96) return CFG_DATA_W'($urandom_range(4000, MAX_DIM));
        if (p < 98) return '0;
        return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 8191));
    endfunction

    initial begin
        int unsigned sent, area, n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset frame is a single pixel; threshold extremes.
        queue_pixel('0, '0);
        queue_pixel('1, '1);

        // Zero dimensions act as one.
        set_frame('0, '0, 13'(ROT_180));
        queue_pixel(8'hA5, 16'h5A5A);

        // Oversized dimensions clamp; the upper data bits of the rotation write are dropped.
        // These two rotations drive the low and the high half of the index to all ones.
        set_frame('1, '1, {11'h7FF, ROT_90});
        queue_random(2);
        wait_drained();
        write_reg(REG_ROTATION, '1);
        close_writes();
        queue_random(1);

        // A write to the unused index must not restart the frame.
        set_frame(13'd3, 13'd2, 13'(ROT_90));
        queue_random(4);
        wait_drained();
        write_reg(REG_UNUSED, '1);
        close_writes();
        queue_random(2);

        // A rotation write in mid frame restarts it.
        set_frame(13'd2, 13'd2, 13'(ROT_180));
        queue_random(2);
        wait_drained();
        write_reg(REG_ROTATION, 13'(ROT_270));
        close_writes();
        queue_random(4);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            wait_drained();
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 4) != 0) write_reg(REG_SRC_WIDTH, pick_dim());
                if ($urandom_range(0, 4) != 0) write_reg(REG_SRC_HEIGHT, pick_dim());
                if ($urandom_range(0, 4) != 0) write_reg(REG_ROTATION, CFG_DATA_W'($urandom));
                if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
                close_writes();
            end
            area = used_dim(width_reg) * used_dim(height_reg);
            if (area > 256) begin
                n = $urandom_range(1, 200);
            end else if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, area);
            end else begin
                n = area * $urandom_range(1, 3);
            end
            if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
            // Sometimes hold the sender in mid frame until every result is back.
            if (n > 1 && $urandom_range(0, 7) == 0) begin
                queue_random(n / 2);
                wait_drained();
                queue_random(n - n / 2);
            end else begin
                queue_random(n);
            end
            sent += n;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
